// ----- rtl/assert_macros.svh -----
// Assertion macros used by the lexer token queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CTL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define CTL_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition");
`else
`define CTL_ASSERT(lbl, clk, rst_n, prop)
`define CTL_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/ctl_pkg.sv -----
// Types, token kinds, keyword table and character classes for the lexer.
package ctl_pkg;

	localparam int KEYWORD_LIMIT = 16;
	localparam int POSITION_BITS = 32;
	localparam int KW_COUNT      = 16;
	localparam int FIFO_DEPTH    = 8;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);
	localparam int MAX_PUSH      = 4;
	localparam int CAND_N        = 6;

	typedef logic [5:0]               kind_t;
	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam kind_t K_NONE = 6'd0;
	localparam kind_t K_LPAREN = 6'd1, K_RPAREN = 6'd2, K_LBRACE = 6'd3, K_RBRACE = 6'd4;
	localparam kind_t K_LBRACK = 6'd5, K_RBRACK = 6'd6, K_COMMA = 6'd7, K_DOT = 6'd8;
	localparam kind_t K_ARROW = 6'd9, K_MINUS = 6'd10, K_DEC = 6'd11, K_SUB_EQ = 6'd12;
	localparam kind_t K_PLUS = 6'd13, K_INC = 6'd14, K_ADD_EQ = 6'd15, K_SLASH = 6'd16;
	localparam kind_t K_STAR = 6'd17, K_SEMI = 6'd18, K_COLON = 6'd19, K_LT = 6'd20;
	localparam kind_t K_SHL = 6'd21, K_LE = 6'd22, K_GT = 6'd24, K_SHR = 6'd25;
	localparam kind_t K_GE = 6'd26, K_ASSIGN = 6'd28, K_EQ = 6'd29, K_NOT = 6'd30;
	localparam kind_t K_NE = 6'd31, K_TILDE = 6'd32, K_AMP = 6'd33, K_AND = 6'd34;
	localparam kind_t K_AND_EQ = 6'd35, K_PCT = 6'd36, K_PCT_EQ = 6'd37, K_QUEST = 6'd38;
	localparam kind_t K_PIPE = 6'd39, K_OR = 6'd40, K_OR_EQ = 6'd41;
	localparam kind_t K_INTEGER = 6'd42, K_IDENT = 6'd43, K_KW0 = 6'd44;

	typedef enum logic [2:0] {
		M_IDLE, M_PUNCT, M_NUM_FIRST, M_NUM_PREFIX, M_NUM_DIGITS, M_IDENT
	} scan_mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] len;
		logic        final_tok;
	} token_t;

	typedef struct packed {
		logic [CAND_N-1:0]        vld;
		token_t [CAND_N-1:0]      tok;
	} cand_t;

	// keyword text, right justified: char i sits at byte (len-1-i)
	localparam logic [127:0] KW_STR [KW_COUNT] = '{
		128'("struct"), 128'("union"), 128'("enum"), 128'("return"),
		128'("constexpr"), 128'("auto"), 128'("static"), 128'("extern"),
		128'({"_Thread", "_local"}), 128'("inline"), 128'("_Noreturn"), 128'("_Alignas"),
		128'("const"), 128'("volatile"), 128'("restrict"), 128'("atomic")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd5, 4'd4, 4'd6, 4'd9, 4'd4, 4'd6, 4'd6,
		4'd13, 4'd6, 4'd9, 4'd8, 4'd5, 4'd8, 4'd8, 4'd6
	};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_prefix(input logic [7:0] c);
		return c == "x" || c == "X" || c == "b" || c == "B";
	endfunction

	function automatic logic has_pair(input logic [7:0] c);
		return c == "-" || c == "+" || c == "<" || c == ">" || c == "=" ||
			c == "!" || c == "&" || c == "%" || c == "|";
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			"(": k = K_LPAREN;  ")": k = K_RPAREN;  "{": k = K_LBRACE;
			"}": k = K_RBRACE;  "[": k = K_LBRACK;  "]": k = K_RBRACK;
			",": k = K_COMMA;   ".": k = K_DOT;     "-": k = K_MINUS;
			"+": k = K_PLUS;    "/": k = K_SLASH;   "*": k = K_STAR;
			";": k = K_SEMI;    ":": k = K_COLON;   "<": k = K_LT;
			">": k = K_GT;      "=": k = K_ASSIGN;  "!": k = K_NOT;
			"~": k = K_TILDE;   "&": k = K_AMP;     "%": k = K_PCT;
			"?": k = K_QUEST;   "|": k = K_PIPE;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
		kind_t k;
		k = K_NONE;
		case (a)
			"-": k = (b == "-") ? K_DEC : (b == ">") ? K_ARROW : (b == "=") ? K_SUB_EQ : K_NONE;
			"+": k = (b == "+") ? K_INC : (b == "=") ? K_ADD_EQ : K_NONE;
			"<": k = (b == "<") ? K_SHL : (b == "=") ? K_LE : K_NONE;
			">": k = (b == ">") ? K_SHR : (b == "=") ? K_GE : K_NONE;
			"=": k = (b == "=") ? K_EQ : K_NONE;
			"!": k = (b == "=") ? K_NE : K_NONE;
			"&": k = (b == "&") ? K_AND : (b == "=") ? K_AND_EQ : K_NONE;
			"%": k = (b == "=") ? K_PCT_EQ : K_NONE;
			"|": k = (b == "|") ? K_OR : (b == "=") ? K_OR_EQ : K_NONE;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	// keywords whose character at idx equals c
	function automatic logic [KW_COUNT-1:0] kw_match(input logic [15:0] idx,
		input logic [7:0] c);
		logic [KW_COUNT-1:0] m;
		logic [3:0]          b;
		m = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			b = KW_LEN[k] - 4'd1 - idx[3:0];
			if (idx < {12'd0, KW_LEN[k]} && KW_STR[k][{b, 3'b000} +: 8] == c)
				m[k] = 1'b1;
		end
		return m;
	endfunction

	function automatic kind_t ident_kind(input logic [KW_COUNT-1:0] cand,
		input logic [15:0] len);
		kind_t k;
		k = K_IDENT;
		if (len < 16'(KEYWORD_LIMIT))
			for (int j = KW_COUNT - 1; j >= 0; j--)
				if (cand[j] && len == {12'd0, KW_LEN[j]})
					k = K_KW0 + 6'(j);
		return k;
	endfunction

endpackage

// ----- rtl/c_token_lexer.sv -----
// Top level of the C token lexer: input register, scanner, token queue.
// Path: a byte is registered in the input stage, held there while stalled, then
// scanned, and its tokens are written into the token queue and read from its head.
// Throughput: one byte per cycle while the token queue has room for four
// tokens; a byte yields at most four tokens, drained one per cycle when not stalled.
// Reset: arst_n clears position, scan state and queue; an end mark resets the scanner too.
module c_token_lexer import ctl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  in_char,
	input  logic        in_last,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [5:0]  token_kind,
	output logic [31:0] token_start,
	output logic [15:0] token_len,
	output logic        token_final
);
	logic       valid_s1, last_s1, room, go;
	logic [7:0] char_s1;
	cand_t      cand;
	token_t     head;

	// the registered byte is scanned once the queue can take its worst case
	assign go         = valid_s1 && room;
	assign char_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!char_stall) valid_s1 <= char_valid;
	end

	// payload of the input stage; held while stalled
	always_ff @(posedge clk) begin
		if (!char_stall) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	ctl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.ch     (char_s1),
		.last   (last_s1),
		.cand   (cand)
	);

	ctl_tok_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (go),
		.cand        (cand),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.head        (head)
	);

	assign token_kind  = head.kind;
	assign token_start = head.start;
	assign token_len   = head.len;
	assign token_final = head.final_tok;
endmodule

// ----- rtl/ctl_scan.sv -----
// Lexer scan state and per-byte token generation.
module ctl_scan import ctl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] ch,
	input  logic       last,
	output cand_t      cand
);
	scan_mode_t          mode_q, mode_d;
	logic [7:0]          held_q, held_d;
	pos_t                pos_q, start_q, start_d, pos_m1, pos_p1, start_p1;
	logic [15:0]         len_q, len_d, len_inc1, len_inc2;
	logic [KW_COUNT-1:0] kwc_q, kwc_d;
	logic                run_idle, dig, alp, spc, pre, par;
	kind_t               pk;

	assign dig      = is_digit(ch);
	assign alp      = is_alpha(ch);
	assign spc      = is_space(ch);
	assign pre      = is_prefix(ch);
	assign par      = has_pair(ch);
	assign pk       = pair_kind(held_q, ch);
	assign pos_m1   = pos_q - 1'b1;
	assign pos_p1   = pos_q + 1'b1;
	assign start_p1 = start_d + 1'b1;
	assign len_inc1 = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
	assign len_inc2 = (len_q >= 16'hFFFE) ? 16'hFFFF : len_q + 16'd2;

	// next state
	always_comb begin
		mode_d   = mode_q;
		held_d   = held_q;
		start_d  = start_q;
		len_d    = len_q;
		kwc_d    = kwc_q;
		run_idle = 1'b0;
		case (mode_q)
			M_IDLE: run_idle = 1'b1;
			M_PUNCT: begin
				if (pk != K_NONE) mode_d = M_IDLE;
				else run_idle = 1'b1;
			end
			M_NUM_FIRST: begin
				if (dig) begin
					len_d  = len_inc1;
					mode_d = M_NUM_DIGITS;
				end else if (pre) begin
					held_d = ch;
					mode_d = M_NUM_PREFIX;
				end else run_idle = 1'b1;
			end
			M_NUM_PREFIX: begin
				if (dig) begin
					len_d  = len_inc2;
					mode_d = M_NUM_DIGITS;
				end else if (alp || dig) begin
					// prefix letter becomes an identifier that continues
					mode_d  = M_IDENT;
					start_d = pos_m1;
					len_d   = 16'd2;
					kwc_d   = kw_match(16'd0, held_q) & kw_match(16'd1, ch);
				end else run_idle = 1'b1;
			end
			M_NUM_DIGITS: begin
				if (dig) len_d = len_inc1;
				else run_idle = 1'b1;
			end
			M_IDENT: begin
				if (alp || dig) begin
					len_d = len_inc1;
					kwc_d = kwc_q & kw_match(len_q, ch);
				end else run_idle = 1'b1;
			end
			default: run_idle = 1'b1;
		endcase
		if (run_idle) begin
			mode_d = M_IDLE;
			if (dig) begin
				mode_d  = M_NUM_FIRST;
				start_d = pos_q;
				len_d   = 16'd1;
			end else if (alp) begin
				mode_d  = M_IDENT;
				start_d = pos_q;
				len_d   = 16'd1;
				kwc_d   = kw_match(16'd0, ch);
			end else if (par) begin
				mode_d  = M_PUNCT;
				held_d  = ch;
				start_d = pos_q;
				len_d   = 16'd1;
			end
		end
	end

	// token candidates: close, prefix identifier, single byte, two flush slots, end
	always_comb begin
		cand = '0;
		case (mode_q)
			M_PUNCT: begin
				cand.vld[0] = 1'b1;
				cand.tok[0] = (pk != K_NONE) ? '{pk, 32'(start_q), 16'd2, 1'b0}
					: '{single_kind(held_q), 32'(start_q), 16'd1, 1'b0};
			end
			M_NUM_FIRST: begin
				cand.vld[0] = !dig && !pre;
				cand.tok[0] = '{K_INTEGER, 32'(start_q), len_q, 1'b0};
			end
			M_NUM_PREFIX: begin
				cand.vld[0] = !dig;
				cand.tok[0] = '{K_INTEGER, 32'(start_q), len_q, 1'b0};
				cand.vld[1] = !dig && !alp;
				cand.tok[1] = '{K_IDENT, 32'(pos_m1), 16'd1, 1'b0};
			end
			M_NUM_DIGITS: begin
				cand.vld[0] = !dig;
				cand.tok[0] = '{K_INTEGER, 32'(start_q), len_q, 1'b0};
			end
			M_IDENT: begin
				cand.vld[0] = !alp && !dig;
				cand.tok[0] = '{ident_kind(kwc_q, len_q), 32'(start_q), len_q, 1'b0};
			end
			default: ;
		endcase
		cand.vld[2] = run_idle && !spc && !dig && !alp && !par;
		cand.tok[2] = '{single_kind(ch), 32'(pos_q), 16'd1, 1'b0};
		if (last) begin
			case (mode_d)
				M_PUNCT: begin
					cand.vld[3] = 1'b1;
					cand.tok[3] = '{single_kind(held_d), 32'(start_d), 16'd1, 1'b0};
				end
				M_NUM_FIRST, M_NUM_DIGITS: begin
					cand.vld[3] = 1'b1;
					cand.tok[3] = '{K_INTEGER, 32'(start_d), len_d, 1'b0};
				end
				M_NUM_PREFIX: begin
					cand.vld[3] = 1'b1;
					cand.tok[3] = '{K_INTEGER, 32'(start_d), len_d, 1'b0};
					cand.vld[4] = 1'b1;
					cand.tok[4] = '{K_IDENT, 32'(start_p1), 16'd1, 1'b0};
				end
				M_IDENT: begin
					cand.vld[3] = 1'b1;
					cand.tok[3] = '{ident_kind(kwc_d, len_d), 32'(start_d), len_d, 1'b0};
				end
				default: ;
			endcase
			cand.vld[5] = 1'b1;
			cand.tok[5] = '{K_NONE, 32'(pos_p1), 16'd0, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			held_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			kwc_q   <= '1;
		end else if (go) begin
			if (last) begin
				mode_q  <= M_IDLE;
				held_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				len_q   <= '0;
				kwc_q   <= '1;
			end else begin
				mode_q  <= mode_d;
				held_q  <= held_d;
				pos_q   <= pos_p1;
				start_q <= start_d;
				len_q   <= len_d;
				kwc_q   <= kwc_d;
			end
		end
	end
endmodule

// ----- rtl/ctl_tok_fifo.sv -----
// Token queue: up to four writes per cycle, one read.
`include "assert_macros.svh"
module ctl_tok_fifo import ctl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cand_t  cand,
	output logic   room,
	output logic   token_valid,
	input  logic   token_stall,
	output token_t head
);
	token_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   count_q, npush;
	logic [PTR_W:0]   off [CAND_N];
	logic             pop;

	always_comb begin
		npush = '0;
		for (int j = 0; j < CAND_N; j++) begin
			off[j] = npush;
			if (push && cand.vld[j]) npush = npush + 1'b1;
		end
	end

	assign pop         = token_valid && !token_stall;
	assign token_valid = count_q != '0;
	assign room        = (FIFO_DEPTH - 32'(count_q)) >= MAX_PUSH;
	assign head        = mem[rd_q];

	always_ff @(posedge clk) begin
		for (int j = 0; j < CAND_N; j++)
			if (push && cand.vld[j])
				mem[wr_q + off[j][PTR_W-1:0]] <= cand.tok[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + npush[PTR_W-1:0];
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + npush - (PTR_W+1)'(pop);
		end
	end

	`CTL_NEVER(a_no_overflow, clk, arst_n, count_q > (PTR_W+1)'(FIFO_DEPTH))
	`CTL_NEVER(a_push_needs_room, clk, arst_n, push && !room)
	`CTL_ASSERT(a_idle_holds, clk, arst_n, (npush == '0 && !pop) |=> $stable(count_q))
endmodule
